/* rtl/core/vnorm_pkg.sv */
// Shared types and constants for the 3-D vector normalize pipeline.
package vnorm_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RemW      = 35;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuoW      = 31;
  localparam int unsigned DivSteps  = 31;
  localparam logic signed [31:0] UnitOne    = 32'sh4000_0000;
  localparam logic signed [31:0] UnitNegOne = -32'sh4000_0000;

  // One input request.
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } vec_in_t;

  // One result.
  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic [31:0]        vec_length;
    logic               zero_length;
  } vec_out_t;

  // Component magnitudes and signs, carried along the pipeline.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } vnorm_mag_t;

  // One square root step state.
  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
    vnorm_mag_t  mv;
  } vnorm_sq_t;

  // One divider step state, three lanes sharing the divisor.
  typedef struct packed {
    logic [31:0]      len;
    logic [2:0][32:0] rem;
    logic [2:0][30:0] quo;
    logic [2:0]       nb;
    vnorm_mag_t       mv;
  } vnorm_dv_t;

endpackage

/* rtl/core/vec3_normalize_unit.sv */
// Top level of the 3-D vector normalize pipeline.
//
// Input channel: in_valid, in_stall, in_req carries vec_x, vec_y, vec_z
// as signed Q16.16. A request is taken on a clock edge with in_valid high
// and in_stall low. Output channel: out_valid, out_stall, out_res carries
// the unit components in signed Q1.30, the length in unsigned Q16.16 and
// the zero_length flag, taken when out_valid is high and out_stall low.
// From accepted request to out_valid the data passes three stages
// for magnitude, squares and sum, 32 square root stages (one root bit
// each), 31 divider stages (one quotient bit each) and the output
// register. Throughput is one request per cycle while the pipeline advances.
// The whole pipeline moves on one advance enable; when the receiver
// stalls a valid result, every stage holds and in_stall goes high, so
// nothing is lost or repeated. A zero vector gives zero components,
// length zero and zero_length set.
// Reset clears all valid bits; no request is in flight afterwards.
module vec3_normalize_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vnorm_pkg::vec_in_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output vnorm_pkg::vec_out_t out_res
);
  import vnorm_pkg::*;

  logic        adv;
  logic        sum_valid;
  logic [63:0] sum;
  vnorm_mag_t  mv_sum;
  logic        len_valid;
  logic [31:0] len;
  vnorm_mag_t  mv_len;
  logic        quo_valid;
  vnorm_dv_t   dv;
  vec_out_t    res_next;

  // The pipeline advances unless a finished result is being held.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  vnorm_sqsum u_sqsum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (in_valid),
    .req       (in_req),
    .sum_valid (sum_valid),
    .sum       (sum),
    .mv        (mv_sum)
  );

  vnorm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sum_valid (sum_valid),
    .sum       (sum),
    .mv_in     (mv_sum),
    .len_valid (len_valid),
    .len       (len),
    .mv        (mv_len)
  );

  vnorm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .len_valid (len_valid),
    .len       (len),
    .mv_in     (mv_len),
    .quo_valid (quo_valid),
    .res       (dv)
  );

  // Apply signs and handle the zero vector.
  always_comb begin
    logic [2:0][31:0] u;
    for (int i = 0; i < 3; i++) begin
      u[i] = dv.mv.neg[i] ? (32'd0 - {1'b0, dv.quo[i]}) : {1'b0, dv.quo[i]};
    end
    res_next.zero_length = (dv.len == 32'd0);
    res_next.vec_length  = dv.len;
    res_next.unit_x      = res_next.zero_length ? '0 : u[0];
    res_next.unit_y      = res_next.zero_length ? '0 : u[1];
    res_next.unit_z      = res_next.zero_length ? '0 : u[2];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.zero_length |-> out_res.vec_length == 32'd0 &&
      out_res.unit_x == 32'sd0 && out_res.unit_y == 32'sd0 && out_res.unit_z == 32'sd0)
    else $error("zero vector result is not all zero");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.unit_x <= UnitOne && out_res.unit_x >= UnitNegOne)
    else $error("unit_x out of range");

  a_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.zero_length |-> out_res.vec_length != 32'd0)
    else $error("nonzero result with zero length");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline could advance");
`endif

endmodule

/* rtl/core/vnorm_sqsum.sv */
// Magnitude, square and sum-of-squares stages.
module vnorm_sqsum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 req_valid,
  input  vnorm_pkg::vec_in_t   req,
  output logic                 sum_valid,
  output logic [63:0]          sum,
  output vnorm_pkg::vnorm_mag_t mv
);
  import vnorm_pkg::*;

  logic [2:0][31:0] raw;
  vnorm_mag_t       m_in;
  vnorm_mag_t       m1;
  vnorm_mag_t       m2;
  logic [2:0][63:0] sq;
  logic             v1;
  logic             v2;

  assign raw = {req.vec_z, req.vec_y, req.vec_x};

  // Two's complement magnitude; the most negative value maps to 2^31.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_in.neg[i] = raw[i][31];
      m_in.mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      v1        <= req_valid;
      v2        <= v1;
      sum_valid <= v2;
    end
  end

  // Magnitude register, then squares, then the sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= m_in;
      m2 <= m1;
      mv <= m2;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= {32'd0, m1.mag[i]} * {32'd0, m1.mag[i]};
      end
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

endmodule

/* rtl/core/vnorm_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module vnorm_isqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  sum_valid,
  input  logic [63:0]           sum,
  input  vnorm_pkg::vnorm_mag_t mv_in,
  output logic                  len_valid,
  output logic [31:0]           len,
  output vnorm_pkg::vnorm_mag_t mv
);
  import vnorm_pkg::*;

  vnorm_sq_t st  [0:SqrtSteps];
  logic      vld [0:SqrtSteps];

  always_comb begin
    st[0].rad  = sum;
    st[0].rem  = '0;
    st[0].root = '0;
    st[0].mv   = mv_in;
    vld[0]     = sum_valid;
  end

  // Each stage brings in two radicand bits and decides one root bit.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic [34:0] t;
    logic [34:0] trial;
    vnorm_sq_t   n;

    always_comb begin
      t      = {st[k].rem[32:0], st[k].rad[63:62]};
      trial  = {1'b0, st[k].root, 2'b01};
      n      = st[k];
      n.rad  = {st[k].rad[61:0], 2'b00};
      if (t >= trial) begin
        n.rem  = t - trial;
        n.root = {st[k].root[30:0], 1'b1};
      end else begin
        n.rem  = t;
        n.root = {st[k].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= n;
      end
    end
  end

  assign len_valid = vld[SqrtSteps];
  assign len       = st[SqrtSteps].root;
  assign mv        = st[SqrtSteps].mv;

endmodule

/* rtl/core/vnorm_div.sv */
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module vnorm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  len_valid,
  input  logic [31:0]           len,
  input  vnorm_pkg::vnorm_mag_t mv_in,
  output logic                  quo_valid,
  output vnorm_pkg::vnorm_dv_t  res
);
  import vnorm_pkg::*;

  vnorm_dv_t st  [0:DivSteps];
  logic      vld [0:DivSteps];

  // The dividend is mag * 2^30 and the quotient fits in 31 bits, so the
  // partial remainder starts with the upper dividend bits.
  always_comb begin
    st[0].len = len;
    st[0].mv  = mv_in;
    st[0].quo = '0;
    for (int i = 0; i < 3; i++) begin
      st[0].rem[i] = {2'b00, mv_in.mag[i][31:1]};
      st[0].nb[i]  = mv_in.mag[i][0];
    end
    vld[0] = len_valid;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [2:0][32:0] t;
    vnorm_dv_t        n;

    always_comb begin
      n    = st[k];
      n.nb = '0;
      for (int i = 0; i < 3; i++) begin
        t[i] = {st[k].rem[i][31:0], st[k].nb[i]};
        if (t[i] >= {1'b0, st[k].len}) begin
          n.rem[i] = t[i] - {1'b0, st[k].len};
          n.quo[i] = {st[k].quo[i][29:0], 1'b1};
        end else begin
          n.rem[i] = t[i];
          n.quo[i] = {st[k].quo[i][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= n;
      end
    end
  end

  assign quo_valid = vld[DivSteps];
  assign res       = st[DivSteps];

endmodule
